>>> rtl/core/bsws_pkg.sv
`timescale 1ns / 1ps

package bsws_pkg;

  // Field widths
  localparam int unsigned OP_W   = 3;
  localparam int unsigned DATA_W = 32;
  localparam int unsigned CAP_W  = 5;
  localparam int unsigned POS_W  = 4;
  localparam int unsigned STAT_W = 2;

  // Defaults
  localparam int unsigned DEPTH_DEFAULT = 16;
  localparam logic [CAP_W-1:0] CAP_RESET = 5'd16;

  // Operation codes
  localparam logic [OP_W-1:0] OP_PUSH   = 3'd0;
  localparam logic [OP_W-1:0] OP_POP    = 3'd1;
  localparam logic [OP_W-1:0] OP_BOTTOM = 3'd2;
  localparam logic [OP_W-1:0] OP_TOP    = 3'd3;
  localparam logic [OP_W-1:0] OP_SEARCH = 3'd4;
  localparam logic [OP_W-1:0] OP_LIST   = 3'd5;

  // Result status codes
  localparam logic [STAT_W-1:0] ST_OK       = 2'd0;
  localparam logic [STAT_W-1:0] ST_FULL     = 2'd1;
  localparam logic [STAT_W-1:0] ST_EMPTY    = 2'd2;
  localparam logic [STAT_W-1:0] ST_NOTFOUND = 2'd3;

  typedef struct packed {
    logic [OP_W-1:0]          operation;
    logic signed [DATA_W-1:0] value;
  } in_item_t;

  typedef struct packed {
    logic [STAT_W-1:0]        status;
    logic signed [DATA_W-1:0] data;
    logic [POS_W-1:0]         position;
    logic                     last;
  } out_item_t;

  typedef enum logic [1:0] {
    CTL_IDLE,
    CTL_EXEC,
    CTL_FLUSH
  } ctl_state_e;

  // What the datapath loads into the output register
  typedef enum logic [2:0] {
    EM_PUSH_OK,
    EM_FULL,
    EM_EMPTY,
    EM_POP_OK,
    EM_READ,
    EM_MATCH,
    EM_NOTFOUND
  } emit_e;

  typedef struct packed {
    logic  accept;
    logic  push_wr;
    logic  pop;
    logic  idx_inc;
    logic  idx_dec;
    logic  pend_set;
    logic  emit;
    emit_e kind;
    logic  last;
  } cmd_t;

  typedef struct packed {
    logic [OP_W-1:0] op;
    logic            empty;
    logic            full;
    logic            match;
    logic            idx_end;
    logic            idx_zero;
    logic            pend_valid;
    logic            out_free;
  } stat_t;

endpackage

>>> rtl/core/bsws_ram.sv
`timescale 1ns / 1ps

module bsws_ram #(
  parameter int unsigned WIDTH = 32,
  parameter int unsigned DEPTH = 16,
  localparam int unsigned AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AW-1:0]    waddr_i,
  input  logic [WIDTH-1:0] wdata_i,
  input  logic [AW-1:0]    raddr_i,
  output logic [WIDTH-1:0] rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  // One write port, one registered read port
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

>>> rtl/core/bsws_ctrl.sv
`timescale 1ns / 1ps

module bsws_ctrl (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      in_valid_i,
  input  logic [bsws_pkg::OP_W-1:0] in_op_i,
  input  bsws_pkg::stat_t           stat_i,
  output bsws_pkg::cmd_t            cmd_o,
  output logic                      busy_o
);

  bsws_pkg::ctl_state_e state_q, state_d;

  // State register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= bsws_pkg::CTL_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  // Next state and commands
  always_comb begin
    state_d = state_q;
    cmd_o   = '0;
    cmd_o.kind = bsws_pkg::EM_EMPTY;
    case (state_q)
      bsws_pkg::CTL_IDLE: begin
        if (in_valid_i) begin
          cmd_o.accept = 1'b1;
          // unknown operations are taken and dropped
          if (in_op_i <= bsws_pkg::OP_LIST) begin
            state_d = bsws_pkg::CTL_EXEC;
          end
        end
      end
      bsws_pkg::CTL_EXEC: begin
        if (stat_i.op == bsws_pkg::OP_PUSH) begin
          if (stat_i.out_free) begin
            cmd_o.emit    = 1'b1;
            cmd_o.last    = 1'b1;
            cmd_o.kind    = stat_i.full ? bsws_pkg::EM_FULL : bsws_pkg::EM_PUSH_OK;
            cmd_o.push_wr = !stat_i.full;
            state_d       = bsws_pkg::CTL_IDLE;
          end
        end else if (stat_i.empty) begin
          if (stat_i.out_free) begin
            cmd_o.emit = 1'b1;
            cmd_o.last = 1'b1;
            cmd_o.kind = bsws_pkg::EM_EMPTY;
            state_d    = bsws_pkg::CTL_IDLE;
          end
        end else begin
          case (stat_i.op)
            bsws_pkg::OP_POP: begin
              if (stat_i.out_free) begin
                cmd_o.emit = 1'b1;
                cmd_o.last = 1'b1;
                cmd_o.kind = bsws_pkg::EM_POP_OK;
                cmd_o.pop  = 1'b1;
                state_d    = bsws_pkg::CTL_IDLE;
              end
            end
            bsws_pkg::OP_BOTTOM, bsws_pkg::OP_TOP: begin
              if (stat_i.out_free) begin
                cmd_o.emit = 1'b1;
                cmd_o.last = 1'b1;
                cmd_o.kind = bsws_pkg::EM_READ;
                state_d    = bsws_pkg::CTL_IDLE;
              end
            end
            bsws_pkg::OP_SEARCH: begin
              // a match is held back one step so the final one can carry last
              if (!(stat_i.match && stat_i.pend_valid && !stat_i.out_free)) begin
                cmd_o.pend_set = stat_i.match;
                cmd_o.emit     = stat_i.match && stat_i.pend_valid;
                cmd_o.kind     = bsws_pkg::EM_MATCH;
                if (stat_i.idx_end) begin
                  state_d = bsws_pkg::CTL_FLUSH;
                end else begin
                  cmd_o.idx_inc = 1'b1;
                end
              end
            end
            bsws_pkg::OP_LIST: begin
              if (stat_i.out_free) begin
                cmd_o.emit = 1'b1;
                cmd_o.last = stat_i.idx_zero;
                cmd_o.kind = bsws_pkg::EM_READ;
                if (stat_i.idx_zero) begin
                  state_d = bsws_pkg::CTL_IDLE;
                end else begin
                  cmd_o.idx_dec = 1'b1;
                end
              end
            end
            default: begin
              state_d = bsws_pkg::CTL_IDLE;
            end
          endcase
        end
      end
      bsws_pkg::CTL_FLUSH: begin
        if (stat_i.out_free) begin
          cmd_o.emit = 1'b1;
          cmd_o.last = 1'b1;
          cmd_o.kind = stat_i.pend_valid ? bsws_pkg::EM_MATCH : bsws_pkg::EM_NOTFOUND;
          state_d    = bsws_pkg::CTL_IDLE;
        end
      end
      default: begin
        state_d = bsws_pkg::CTL_IDLE;
      end
    endcase
  end

  assign busy_o = (state_q != bsws_pkg::CTL_IDLE);

endmodule

>>> rtl/core/bsws_dpath.sv
`timescale 1ns / 1ps

module bsws_dpath #(
  parameter int unsigned DEPTH = bsws_pkg::DEPTH_DEFAULT
) (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       cfg_wr_en_i,
  input  logic [bsws_pkg::CAP_W-1:0] cfg_wr_data_i,
  input  bsws_pkg::in_item_t         in_data_i,
  output logic                       out_valid_o,
  input  logic                       out_stall_i,
  output bsws_pkg::out_item_t        out_data_o,
  input  bsws_pkg::cmd_t             cmd_i,
  output bsws_pkg::stat_t            stat_o
);

  localparam int unsigned AW   = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned CW   = $clog2(DEPTH + 1);
  localparam int unsigned CMPW = (CW > bsws_pkg::CAP_W) ? CW : bsws_pkg::CAP_W;
  localparam int unsigned PW   = AW + bsws_pkg::POS_W;

  logic [bsws_pkg::CAP_W-1:0]  cap_q;
  logic [CW-1:0]               cnt_q, cnt_m1;
  logic [bsws_pkg::OP_W-1:0]   op_q;
  logic [bsws_pkg::DATA_W-1:0] key_q;
  logic [AW-1:0]               idx_q, idx_d;
  logic                        pend_valid_q;
  logic [AW-1:0]               pend_pos_q;
  logic                        out_valid_q;
  bsws_pkg::out_item_t         out_q, out_d;
  logic [bsws_pkg::DATA_W-1:0] rdata;
  logic [CMPW-1:0]             cap_ext, cap_eff, depth_c;
  logic                        full, out_free;

  // Entry index to the fixed 4-bit position field
  function automatic logic [bsws_pkg::POS_W-1:0] pos_of(input logic [AW-1:0] a);
    logic [PW-1:0] e;
    e = PW'(a);
    return e[bsws_pkg::POS_W-1:0];
  endfunction

  assign cnt_m1 = cnt_q - 1'b1;

  // Capacity clamped to 1..DEPTH
  assign cap_ext = CMPW'(cap_q);
  assign depth_c = CMPW'(DEPTH);
  always_comb begin
    if (cap_q == '0) begin
      cap_eff = CMPW'(1);
    end else if (cap_ext > depth_c) begin
      cap_eff = depth_c;
    end else begin
      cap_eff = cap_ext;
    end
  end
  assign full = (CMPW'(cnt_q) >= cap_eff);

  // Capacity register and entry count
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cap_q <= bsws_pkg::CAP_RESET;
      cnt_q <= '0;
    end else begin
      if (cfg_wr_en_i) begin
        cap_q <= cfg_wr_data_i;
      end
      if (cmd_i.push_wr) begin
        cnt_q <= cnt_q + 1'b1;
      end else if (cmd_i.pop) begin
        cnt_q <= cnt_m1;
      end
    end
  end

  // Scan index; the RAM reads at the next index so data lines up with idx_q
  always_comb begin
    idx_d = idx_q;
    if (cmd_i.accept) begin
      if (in_data_i.operation == bsws_pkg::OP_TOP ||
          in_data_i.operation == bsws_pkg::OP_LIST) begin
        idx_d = cnt_m1[AW-1:0];
      end else begin
        idx_d = '0;
      end
    end else if (cmd_i.idx_inc) begin
      idx_d = idx_q + 1'b1;
    end else if (cmd_i.idx_dec) begin
      idx_d = idx_q - 1'b1;
    end
  end

  // Item latch and scan index
  always_ff @(posedge clk_i) begin
    if (cmd_i.accept) begin
      op_q  <= in_data_i.operation;
      key_q <= in_data_i.value;
    end
    idx_q <= idx_d;
    if (cmd_i.pend_set) begin
      pend_pos_q <= idx_q;
    end
  end

  // Held-back search match
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pend_valid_q <= 1'b0;
    end else if (cmd_i.accept) begin
      pend_valid_q <= 1'b0;
    end else if (cmd_i.pend_set) begin
      pend_valid_q <= 1'b1;
    end
  end

  bsws_ram #(
    .WIDTH (bsws_pkg::DATA_W),
    .DEPTH (DEPTH)
  ) u_ram (
    .clk_i   (clk_i),
    .we_i    (cmd_i.push_wr),
    .waddr_i (cnt_q[AW-1:0]),
    .wdata_i (key_q),
    .raddr_i (idx_d),
    .rdata_o (rdata)
  );

  // Output register
  assign out_free = !out_valid_q || !out_stall_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (cmd_i.emit) begin
      out_valid_q <= 1'b1;
    end else if (!out_stall_i) begin
      out_valid_q <= 1'b0;
    end
  end

  // Next result beat
  always_comb begin
    out_d        = '0;
    out_d.status = bsws_pkg::ST_OK;
    out_d.last   = cmd_i.last;
    case (cmd_i.kind)
      bsws_pkg::EM_PUSH_OK: out_d.position = pos_of(cnt_q[AW-1:0]);
      bsws_pkg::EM_FULL:    out_d.status   = bsws_pkg::ST_FULL;
      bsws_pkg::EM_EMPTY:   out_d.status   = bsws_pkg::ST_EMPTY;
      bsws_pkg::EM_POP_OK:  out_d.position = pos_of(cnt_m1[AW-1:0]);
      bsws_pkg::EM_READ: begin
        out_d.data     = rdata;
        out_d.position = pos_of(idx_q);
      end
      bsws_pkg::EM_MATCH:    out_d.position = pos_of(pend_pos_q);
      bsws_pkg::EM_NOTFOUND: out_d.status   = bsws_pkg::ST_NOTFOUND;
      default:               out_d.status   = bsws_pkg::ST_EMPTY;
    endcase
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.emit) begin
      out_q <= out_d;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

  // Status to the controller
  assign stat_o.op         = op_q;
  assign stat_o.empty      = (cnt_q == '0);
  assign stat_o.full       = full;
  assign stat_o.match      = (rdata == key_q);
  assign stat_o.idx_end    = (idx_q == cnt_m1[AW-1:0]);
  assign stat_o.idx_zero   = (idx_q == '0);
  assign stat_o.pend_valid = pend_valid_q;
  assign stat_o.out_free   = out_free;

`ifndef SYNTH
  a_cnt_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    CMPW'(cnt_q) <= depth_c)
    else $error("entry count above depth");
  a_push_not_full: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.push_wr |-> !full)
    else $error("push written while full");
  a_pop_not_empty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.pop |-> (cnt_q != '0))
    else $error("pop on empty stack");
  a_emit_free: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.emit |-> out_free)
    else $error("result overwrote a waiting beat");
`endif

endmodule

>>> rtl/core/bounded_stack_with_search.sv
`timescale 1ns / 1ps
// Channel  | Handshake              | Beat
// ---------+------------------------+--------------------------------------
// cfg      | cfg_wr_en_i            | cfg_wr_data_i: capacity
// in       | in_valid_i / in_stall_o | in_data_i: operation, value
// out      | out_valid_o / out_stall_i | out_data_o: status, data, position, last
//
// One operation at a time; in_stall_o is high from accept until its last beat
// is loaded into the output register. Search and list walk the entry RAM
// through its single registered read port, one entry per cycle unless a
// result beat has to wait for a stalled output.
// Reset empties the stack and sets capacity to 16; RAM contents are not cleared.
// A stalled output holds the scan only when a new beat is due and the waiting beat has not been taken.

module bounded_stack_with_search #(
  parameter int unsigned DEPTH = bsws_pkg::DEPTH_DEFAULT
) (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       cfg_wr_en_i,
  input  logic [bsws_pkg::CAP_W-1:0] cfg_wr_data_i,
  input  logic                       in_valid_i,
  output logic                       in_stall_o,
  input  bsws_pkg::in_item_t         in_data_i,
  output logic                       out_valid_o,
  input  logic                       out_stall_i,
  output bsws_pkg::out_item_t        out_data_o
);

  bsws_pkg::cmd_t  cmd;
  bsws_pkg::stat_t stat;

  bsws_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_op_i    (in_data_i.operation),
    .stat_i     (stat),
    .cmd_o      (cmd),
    .busy_o     (in_stall_o)
  );

  bsws_dpath #(
    .DEPTH (DEPTH)
  ) u_dpath (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_wr_en_i   (cfg_wr_en_i),
    .cfg_wr_data_i (cfg_wr_data_i),
    .in_data_i     (in_data_i),
    .out_valid_o   (out_valid_o),
    .out_stall_i   (out_stall_i),
    .out_data_o    (out_data_o),
    .cmd_i         (cmd),
    .stat_o        (stat)
  );

endmodule

>>> verif/tb.sv
`timescale 1ns / 1ps

module tb;

  localparam int unsigned OP_W          = bsws_pkg::OP_W;
  localparam int unsigned DATA_W        = bsws_pkg::DATA_W;
  localparam int unsigned CAP_W         = bsws_pkg::CAP_W;
  localparam int unsigned POS_W         = bsws_pkg::POS_W;
  localparam int unsigned STACK_DEPTH   = bsws_pkg::DEPTH_DEFAULT;
  localparam int unsigned CYCLE_LIMIT   = 600000;
  localparam int unsigned DRAIN_LIMIT   = 20000;
  localparam int unsigned SETTLE_CYCLES = 40;
  localparam int unsigned RANDOM_ITEMS  = 160;

  // Operation codes the block ignores
  localparam logic [OP_W-1:0] OP_RSVD_A = 3'd6;
  localparam logic [OP_W-1:0] OP_RSVD_B = 3'd7;

  logic                 clk;
  logic                 rst_n;
  logic                 cfg_wr_en;
  logic [CAP_W-1:0]     cfg_wr_data;
  logic                 in_valid;
  logic                 in_stall;
  bsws_pkg::in_item_t   in_beat;
  logic                 out_valid;
  logic                 out_stall = 1'b0;
  bsws_pkg::out_item_t  out_beat;

  // Shadow copy of the stack, its fill level and the capacity register
  logic signed [DATA_W-1:0] stack_words [STACK_DEPTH];
  int unsigned              word_count = 0;
  logic [CAP_W-1:0]         capacity_reg = bsws_pkg::CAP_RESET;

  bsws_pkg::out_item_t pending_results [$];
  int unsigned err_count = 0;
  int unsigned cycle_count = 0;
  int unsigned send_gap_pct = 0;
  int unsigned recv_stall_pct = 0;

  bounded_stack_with_search #(
    .DEPTH(STACK_DEPTH)
  ) DUT (
    .clk_i        (clk),
    .rst_ni       (rst_n),
    .cfg_wr_en_i  (cfg_wr_en),
    .cfg_wr_data_i(cfg_wr_data),
    .in_valid_i   (in_valid),
    .in_stall_o   (in_stall),
    .in_data_i    (in_beat),
    .out_valid_o  (out_valid),
    .out_stall_i  (out_stall),
    .out_data_o   (out_beat)
  );

  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  // Run limit
  always @(posedge clk) cycle_count <= cycle_count + 1;

  initial begin
    wait (cycle_count >= CYCLE_LIMIT);
    $display("tb: FAIL");
    $finish;
  end

  function automatic void check_field(string name, logic [DATA_W-1:0] want,
                                      logic [DATA_W-1:0] got);
    if (want !== got) begin
      $display("%0t: %s mismatch: expected 0x%h, got 0x%h", $time, name, want, got);
      err_count++;
    end
  endfunction

  // Output side: random stall, check each accepted beat against the oldest expectation
  always @(posedge clk) begin
    bsws_pkg::out_item_t want;
    if (rst_n && out_valid && !out_stall) begin
      if (pending_results.size() == 0) begin
        $display("%0t: unexpected result beat: expected none, got %p", $time, out_beat);
        err_count++;
      end else begin
        want = pending_results.pop_front();
        check_field("status", DATA_W'(want.status), DATA_W'(out_beat.status));
        check_field("data", want.data, out_beat.data);
        check_field("position", DATA_W'(want.position), DATA_W'(out_beat.position));
        check_field("last", DATA_W'(want.last), DATA_W'(out_beat.last));
      end
    end
    out_stall <= ($urandom_range(99) < recv_stall_pct);
  end

  // Work out the result beats of one accepted operation and update the shadow stack
  function automatic void predict_stack_op(logic [OP_W-1:0] op,
                                           logic signed [DATA_W-1:0] key);
    int unsigned         cap;
    int unsigned         hits;
    bsws_pkg::out_item_t beat;
    cap  = (capacity_reg == 0) ? 1 :
           (capacity_reg > STACK_DEPTH) ? STACK_DEPTH : capacity_reg;
    beat = '0;
    beat.status = bsws_pkg::ST_OK;
    beat.last   = 1'b1;
    if (op == OP_RSVD_A || op == OP_RSVD_B) return;
    if (op == bsws_pkg::OP_PUSH) begin
      if (word_count >= cap || word_count >= STACK_DEPTH) begin
        beat.status = bsws_pkg::ST_FULL;
      end else begin
        stack_words[word_count] = key;
        beat.position = POS_W'(word_count);
        word_count++;
      end
      pending_results.push_back(beat);
    end else if (word_count == 0) begin
      beat.status = bsws_pkg::ST_EMPTY;
      pending_results.push_back(beat);
    end else begin
      case (op)
        bsws_pkg::OP_POP: begin
          word_count--;
          beat.position = POS_W'(word_count);
          pending_results.push_back(beat);
        end
        bsws_pkg::OP_BOTTOM: begin
          beat.data = stack_words[0];
          pending_results.push_back(beat);
        end
        bsws_pkg::OP_TOP: begin
          beat.data     = stack_words[word_count-1];
          beat.position = POS_W'(word_count - 1);
          pending_results.push_back(beat);
        end
        bsws_pkg::OP_SEARCH: begin
          // scan occupied entries bottom up; last flag on the final match
          hits = 0;
          for (int i = 0; i < word_count; i++) begin
            if (stack_words[i] == key) hits++;
          end
          if (hits == 0) begin
            beat.status = bsws_pkg::ST_NOTFOUND;
            pending_results.push_back(beat);
          end else begin
            for (int i = 0; i < word_count; i++) begin
              if (stack_words[i] == key) begin
                hits--;
                beat.position = POS_W'(i);
                beat.last     = (hits == 0);
                pending_results.push_back(beat);
              end
            end
          end
        end
        default: begin
          // list: top down
          for (int i = word_count; i > 0; i--) begin
            beat.data     = stack_words[i-1];
            beat.position = POS_W'(i - 1);
            beat.last     = (i == 1);
            pending_results.push_back(beat);
          end
        end
      endcase
    end
  endfunction

  // Send one beat; valid stays high afterwards unless the next call idles first
  task automatic send_item(logic [OP_W-1:0] op, logic signed [DATA_W-1:0] value);
    bsws_pkg::in_item_t beat;
    beat.operation = op;
    beat.value     = value;
    if (send_gap_pct != 0 && $urandom_range(99) < send_gap_pct) begin
      in_valid <= 1'b0;
      do @(posedge clk); while ($urandom_range(99) < send_gap_pct);
    end
    in_valid <= 1'b1;
    in_beat  <= beat;
    do @(posedge clk); while (in_stall);
    predict_stack_op(op, value);
  endtask

  // Stop sending, wait for all expected beats, then let the block settle
  task automatic wait_idle();
    int unsigned waited;
    in_valid <= 1'b0;
    waited = 0;
    while (pending_results.size() != 0 && waited < DRAIN_LIMIT) begin
      @(posedge clk);
      waited++;
    end
    if (pending_results.size() != 0) begin
      $display("%0t: %0d result beats missing, next expected %p, got none",
               $time, pending_results.size(), pending_results[0]);
      err_count++;
      pending_results.delete();
    end
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_capacity(logic [CAP_W-1:0] value);
    cfg_wr_en   <= 1'b1;
    cfg_wr_data <= value;
    @(posedge clk);
    capacity_reg = value;
    cfg_wr_en   <= 1'b0;
  endtask

  // Half the words from a small pool so searches find several matches
  function automatic logic signed [DATA_W-1:0] pick_word();
    if ($urandom_range(1)) return $urandom;
    case ($urandom_range(3))
      0: return 32'sh8000_0000;
      1: return 32'sh7fff_ffff;
      2: return -1;
      default: return 5;
    endcase
  endfunction

  function automatic logic signed [DATA_W-1:0] pick_key();
    if (word_count != 0 && $urandom_range(1)) return stack_words[$urandom_range(word_count - 1)];
    return pick_word();
  endfunction

  task automatic test_empty_stack();
    send_item(bsws_pkg::OP_POP, 0);
    send_item(bsws_pkg::OP_BOTTOM, 0);
    send_item(bsws_pkg::OP_TOP, 0);
    send_item(bsws_pkg::OP_SEARCH, 0);
    send_item(bsws_pkg::OP_LIST, 0);
    send_item(OP_RSVD_A, -1);
    send_item(OP_RSVD_B, 32'sh5a5a_a5a5);
    wait_idle();
  endtask

  task automatic test_value_extremes();
    send_item(bsws_pkg::OP_PUSH, 32'sh8000_0000);
    send_item(bsws_pkg::OP_PUSH, 32'sh7fff_ffff);
    send_item(bsws_pkg::OP_PUSH, 0);
    send_item(bsws_pkg::OP_PUSH, -1);
    send_item(bsws_pkg::OP_PUSH, 32'shaaaa_aaaa);
    send_item(bsws_pkg::OP_PUSH, 32'sh5555_5555);
    send_item(bsws_pkg::OP_PUSH, -1);
    send_item(bsws_pkg::OP_BOTTOM, 0);
    send_item(bsws_pkg::OP_TOP, 0);
    send_item(bsws_pkg::OP_SEARCH, -1);
    send_item(bsws_pkg::OP_SEARCH, 32'sh8000_0000);
    send_item(bsws_pkg::OP_SEARCH, 12345);
    send_item(OP_RSVD_B, 0);
    send_item(bsws_pkg::OP_LIST, 0);
    repeat (8) send_item(bsws_pkg::OP_POP, 0);
    wait_idle();
  endtask

  // Capacity of one, zero acting as one, and capacity lowered below the fill level
  task automatic test_capacity_limits();
    write_capacity(5'd1);
    send_item(bsws_pkg::OP_PUSH, 11);
    send_item(bsws_pkg::OP_PUSH, 12);
    send_item(bsws_pkg::OP_POP, 0);
    wait_idle();
    write_capacity(5'd0);
    send_item(bsws_pkg::OP_PUSH, 21);
    send_item(bsws_pkg::OP_PUSH, 22);
    send_item(bsws_pkg::OP_TOP, 0);
    send_item(bsws_pkg::OP_POP, 0);
    wait_idle();
    write_capacity(5'd16);
    send_item(bsws_pkg::OP_PUSH, 31);
    send_item(bsws_pkg::OP_PUSH, 32);
    send_item(bsws_pkg::OP_PUSH, 31);
    send_item(bsws_pkg::OP_PUSH, 34);
    wait_idle();
    write_capacity(5'd2);
    send_item(bsws_pkg::OP_PUSH, 35);
    send_item(bsws_pkg::OP_LIST, 0);
    send_item(bsws_pkg::OP_SEARCH, 31);
    send_item(bsws_pkg::OP_POP, 0);
    send_item(bsws_pkg::OP_POP, 0);
    send_item(bsws_pkg::OP_PUSH, 36);
    send_item(bsws_pkg::OP_POP, 0);
    send_item(bsws_pkg::OP_PUSH, 37);
    repeat (3) send_item(bsws_pkg::OP_POP, 0);
    wait_idle();
    write_capacity(bsws_pkg::CAP_RESET);
  endtask

  // Bursts of pushes, queries and pops with some unknown-operation noise
  task automatic run_random_items(int unsigned count);
    int unsigned      sent;
    logic [OP_W-1:0]  op;
    sent = 0;
    while (sent < count) begin
      case ($urandom_range(9))
        0, 1, 2, 3: begin
          repeat ($urandom_range(1, 8)) begin
            send_item(bsws_pkg::OP_PUSH, pick_word());
            sent++;
          end
        end
        4, 5: begin
          repeat ($urandom_range(1, 4)) begin
            case ($urandom_range(3))
              0: send_item(bsws_pkg::OP_BOTTOM, $urandom);
              1: send_item(bsws_pkg::OP_TOP, $urandom);
              default: send_item(bsws_pkg::OP_SEARCH, pick_key());
            endcase
            sent++;
          end
        end
        6, 7: begin
          repeat ($urandom_range(1, 8)) begin
            send_item(bsws_pkg::OP_POP, $urandom);
            sent++;
          end
        end
        8: begin
          send_item(bsws_pkg::OP_LIST, $urandom);
          sent++;
        end
        default: begin
          op = OP_W'($urandom_range(7));
          send_item(op, $urandom);
          if (op != OP_RSVD_A && op != OP_RSVD_B) sent++;
        end
      endcase
    end
  endtask

  task automatic test_random_traffic();
    int unsigned      gap_pct   [4] = '{0, 59, 0, 13};
    int unsigned      stall_pct [4] = '{0, 0, 59, 13};
    logic [CAP_W-1:0] caps      [8] = '{5'd31, 5'd4, 5'd16, 5'd0, 5'd17, 5'd1, 5'd9, 5'd31};
    for (int p = 0; p < 8; p++) begin
      wait_idle();
      write_capacity((p == 6) ? CAP_W'($urandom_range(31)) : caps[p]);
      send_gap_pct   = gap_pct[p/2];
      recv_stall_pct = stall_pct[p/2];
      run_random_items(RANDOM_ITEMS / 8);
    end
    wait_idle();
    send_gap_pct   = 0;
    recv_stall_pct = 0;
  endtask

  initial begin
    rst_n       <= 1'b0;
    cfg_wr_en   <= 1'b0;
    cfg_wr_data <= '0;
    in_valid    <= 1'b0;
    in_beat     <= '0;
    repeat (6) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    test_empty_stack();
    test_value_extremes();
    test_capacity_limits();
    test_random_traffic();
    wait_idle();
    if (err_count == 0) begin
      $display("tb: PASS");
    end else begin
      $display("tb: FAIL");
    end
    $finish;
  end

endmodule
